// ===== rtl/core/frasm_pkg.sv =====
`timescale 1ns / 1ps

package frasm_pkg;

    // Fixed field widths of the item and result beats
    localparam int OP_W    = 2;
    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 12;
    localparam int STAT_W  = 3;
    localparam int FRAG_W  = 16;

    localparam int MAX_MSG_BYTES_DEF = 4096;
    localparam int SEQ_BITS_DEF      = 16;

    typedef enum logic [OP_W-1:0] {
        OP_HDR     = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_READ    = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_MORE       = 3'd0,
        ST_FRAG_DONE  = 3'd1,
        ST_COMPLETE   = 3'd2,
        ST_SEQ_ERR    = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_INCOMPLETE = 3'd5,
        ST_UNEXPECTED = 3'd6,
        ST_READ       = 3'd7
    } t_status;

endpackage

// ===== rtl/core/frasm_ram.sv =====
`timescale 1ns / 1ps

module frasm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fragment_reassembly.sv =====
// Each result beat passes two result slots (read stage, output register), which
// absorb output stall. Throughput: one item per cycle, headers, payload bytes
// and reads alike, unless an output stall holds the read stage; the message
// buffer is a simple dual-port RAM with one write and one read a cycle.
// Reset (synchronous, active low) clears the control state; buffer contents
// are left as they were; reads return them only below the received byte count.
`timescale 1ns / 1ps

module fragment_reassembly #(
    parameter int MAX_MSG_BYTES = frasm_pkg::MAX_MSG_BYTES_DEF,
    parameter int SEQ_BITS      = frasm_pkg::SEQ_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [frasm_pkg::OP_W-1:0]     i_op,
    input  logic [frasm_pkg::SEQ_W-1:0]    i_seq_id,
    input  logic [frasm_pkg::LEN_W-1:0]    i_msg_len,
    input  logic [frasm_pkg::LEN_W-1:0]    i_frag_size,
    input  logic                           i_last_flag,
    input  logic [frasm_pkg::BYTE_W-1:0]   i_payload_byte,
    input  logic [frasm_pkg::IDX_W-1:0]    i_read_index,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [frasm_pkg::STAT_W-1:0]   o_status,
    output logic [frasm_pkg::LEN_W-1:0]    o_message_length,
    output logic [frasm_pkg::FRAG_W-1:0]   o_fragment_total,
    output logic [frasm_pkg::BYTE_W-1:0]   o_read_byte
);

    localparam int AW    = $clog2(MAX_MSG_BYTES);
    localparam int LEN_W = frasm_pkg::LEN_W;

    // message state
    logic [LEN_W-1:0]              r_rcv_cnt,    n_rcv_cnt;
    logic [LEN_W-1:0]              r_exp_len,    n_exp_len;
    logic [SEQ_BITS-1:0]           r_last_seq,   n_last_seq;
    logic [frasm_pkg::FRAG_W-1:0]  r_frag_cnt,   n_frag_cnt;
    logic                          r_active,     n_active;
    logic [LEN_W-1:0]              r_bytes_left, n_bytes_left;
    logic [frasm_pkg::SEQ_W-1:0]   r_pend_seq,   n_pend_seq;
    logic                          r_pend_last,  n_pend_last;

    // result pipeline
    logic                          r_s1_valid;
    frasm_pkg::t_status            r_s1_status;
    logic [LEN_W-1:0]              r_s1_len;
    logic [frasm_pkg::FRAG_W-1:0]  r_s1_frag;
    logic                          r_s1_rd_ok;
    logic                          r_out_valid;
    frasm_pkg::t_status            r_out_status;
    logic [LEN_W-1:0]              r_out_len;
    logic [frasm_pkg::FRAG_W-1:0]  r_out_frag;
    logic [frasm_pkg::BYTE_W-1:0]  r_out_byte;

    logic                          in_acc;
    logic                          s1_adv;
    frasm_pkg::t_op                op;
    frasm_pkg::t_status            status;
    logic                          rd_ok;
    logic                          mem_we;
    logic                          mem_re;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [frasm_pkg::BYTE_W-1:0]  mem_rdata;

    // header view of the state after a possible restart
    logic                          hdr_restart;
    logic                          hdr_too_long;
    logic [LEN_W-1:0]              h_rcv_cnt;
    logic [LEN_W-1:0]              h_exp_len;
    logic [SEQ_BITS-1:0]           h_last_seq;
    logic [SEQ_BITS-1:0]           h_seq_exp;
    logic [frasm_pkg::FRAG_W-1:0]  h_frag_cnt;
    logic                          h_active;
    logic                          h_seq_ok;
    logic                          h_fits;
    logic [LEN_W-1:0]              p_rcv_inc;

    assign op = frasm_pkg::t_op'(i_op);

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign hdr_restart  = (i_seq_id == frasm_pkg::SEQ_W'(1));
    assign hdr_too_long = hdr_restart && (32'(i_msg_len) > MAX_MSG_BYTES);
    assign h_rcv_cnt    = hdr_restart ? '0 : r_rcv_cnt;
    assign h_exp_len    = hdr_restart ? i_msg_len : r_exp_len;
    assign h_last_seq   = hdr_restart ? '0 : r_last_seq;
    assign h_frag_cnt   = hdr_restart ? '0 : r_frag_cnt;
    assign h_active     = hdr_restart ? 1'b1 : r_active;
    assign h_seq_exp    = SEQ_BITS'(h_last_seq + SEQ_BITS'(1));
    assign h_seq_ok     = h_active && (32'(i_seq_id) == 32'(h_seq_exp));
    assign h_fits       = ((LEN_W+1)'(h_rcv_cnt) + (LEN_W+1)'(i_frag_size))
                          <= (LEN_W+1)'(h_exp_len);
    assign p_rcv_inc    = r_rcv_cnt + LEN_W'(1);

    assign rd_ok = (32'(i_read_index) < 32'(r_rcv_cnt))
                   && (32'(i_read_index) < MAX_MSG_BYTES);

    always_comb begin
        n_rcv_cnt    = r_rcv_cnt;
        n_exp_len    = r_exp_len;
        n_last_seq   = r_last_seq;
        n_frag_cnt   = r_frag_cnt;
        n_active     = r_active;
        n_bytes_left = r_bytes_left;
        n_pend_seq   = r_pend_seq;
        n_pend_last  = r_pend_last;
        status       = frasm_pkg::ST_UNEXPECTED;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        case (op)
            frasm_pkg::OP_HDR: begin
                // a header always abandons any unfinished fragment
                n_bytes_left = '0;
                if (hdr_restart) begin
                    n_rcv_cnt  = '0;
                    n_last_seq = '0;
                    n_frag_cnt = '0;
                end
                if (hdr_too_long) begin
                    n_exp_len = '0;
                    n_active  = 1'b0;
                    status    = frasm_pkg::ST_OVERFLOW;
                end else begin
                    if (hdr_restart) begin
                        n_exp_len = i_msg_len;
                        n_active  = 1'b1;
                    end
                    if (!h_seq_ok) begin
                        status = frasm_pkg::ST_SEQ_ERR;
                    end else if (!h_fits) begin
                        status = frasm_pkg::ST_OVERFLOW;
                    end else begin
                        n_pend_seq   = i_seq_id;
                        n_pend_last  = i_last_flag;
                        n_bytes_left = i_frag_size;
                        if (i_frag_size == '0) begin
                            // empty fragment closes at once
                            n_last_seq = SEQ_BITS'(i_seq_id);
                            n_frag_cnt = h_frag_cnt + frasm_pkg::FRAG_W'(1);
                            if (!i_last_flag) begin
                                status = frasm_pkg::ST_FRAG_DONE;
                            end else if (h_rcv_cnt != h_exp_len) begin
                                status = frasm_pkg::ST_INCOMPLETE;
                            end else begin
                                n_active = 1'b0;
                                status   = frasm_pkg::ST_COMPLETE;
                            end
                        end else begin
                            status = frasm_pkg::ST_MORE;
                        end
                    end
                end
            end
            frasm_pkg::OP_PAYLOAD: begin
                if (r_bytes_left == '0) begin
                    status = frasm_pkg::ST_UNEXPECTED;
                end else begin
                    mem_we       = 32'(r_rcv_cnt) < MAX_MSG_BYTES;
                    n_rcv_cnt    = p_rcv_inc;
                    n_bytes_left = r_bytes_left - LEN_W'(1);
                    if (r_bytes_left == LEN_W'(1)) begin
                        n_last_seq = SEQ_BITS'(r_pend_seq);
                        n_frag_cnt = r_frag_cnt + frasm_pkg::FRAG_W'(1);
                        if (!r_pend_last) begin
                            status = frasm_pkg::ST_FRAG_DONE;
                        end else if (p_rcv_inc != r_exp_len) begin
                            status = frasm_pkg::ST_INCOMPLETE;
                        end else begin
                            n_active = 1'b0;
                            status   = frasm_pkg::ST_COMPLETE;
                        end
                    end else begin
                        status = frasm_pkg::ST_MORE;
                    end
                end
            end
            frasm_pkg::OP_READ: begin
                status = frasm_pkg::ST_READ;
                mem_re = 1'b1;
            end
            default: begin
                status = frasm_pkg::ST_UNEXPECTED;
            end
        endcase
    end

    assign mem_waddr = AW'(r_rcv_cnt);
    assign mem_raddr = AW'(i_read_index);

    frasm_ram #(
        .WIDTH (frasm_pkg::BYTE_W),
        .DEPTH (MAX_MSG_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (in_acc && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_payload_byte),
        .i_re    (in_acc && mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcv_cnt    <= '0;
            r_exp_len    <= '0;
            r_last_seq   <= '0;
            r_frag_cnt   <= '0;
            r_active     <= 1'b0;
            r_bytes_left <= '0;
            r_pend_seq   <= '0;
            r_pend_last  <= 1'b0;
        end else if (in_acc) begin
            r_rcv_cnt    <= n_rcv_cnt;
            r_exp_len    <= n_exp_len;
            r_last_seq   <= n_last_seq;
            r_frag_cnt   <= n_frag_cnt;
            r_active     <= n_active;
            r_bytes_left <= n_bytes_left;
            r_pend_seq   <= n_pend_seq;
            r_pend_last  <= n_pend_last;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage 1 waits on the RAM read; read data joins the beat on the way out
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= status;
            r_s1_len    <= n_exp_len;
            r_s1_frag   <= n_frag_cnt;
            r_s1_rd_ok  <= mem_re && rd_ok;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
            r_out_frag   <= r_s1_frag;
            r_out_byte   <= r_s1_rd_ok ? mem_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_message_length = r_out_len;
    assign o_fragment_total = r_out_frag;
    assign o_read_byte      = r_out_byte;

`ifndef NO_ASSERTIONS
    // a due fragment always fits in the declared length
    a_bytes_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((LEN_W+1)'(r_bytes_left) + (LEN_W+1)'(r_rcv_cnt)) <= (LEN_W+1)'(r_exp_len))
        else $error("bytes due exceed declared message length");

    a_idle_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_bytes_left == '0))
        else $error("payload due with no active message");

    a_write_only_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && mem_we) |-> (r_bytes_left != '0))
        else $error("buffer write without a due payload byte");

    // a held read beat must keep its RAM data: no new read behind it
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !(in_acc && mem_re))
        else $error("RAM read issued while stage 1 is held");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != frasm_pkg::ST_READ)) |-> (o_read_byte == '0))
        else $error("nonzero read byte on a non-read result");
`endif

endmodule

// ===== tb/sv/fragment_reassembly_test.sv =====
`timescale 1ns / 1ps

module fragment_reassembly_test;

    localparam int          OP_W           = frasm_pkg::OP_W;
    localparam int          SEQ_W          = frasm_pkg::SEQ_W;
    localparam int          LEN_W          = frasm_pkg::LEN_W;
    localparam int          BYTE_W         = frasm_pkg::BYTE_W;
    localparam int          IDX_W          = frasm_pkg::IDX_W;
    localparam int          STAT_W         = frasm_pkg::STAT_W;
    localparam int          FRAG_W         = frasm_pkg::FRAG_W;

    localparam int          RESET_CYCLES   = 8;
    localparam int          MAX_BYTES      = frasm_pkg::MAX_MSG_BYTES_DEF;
    localparam int          TARGET_ITEMS   = 1650;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          MAX_REPORTS    = 60;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEQ_W-1:0]  seq_id;
        logic [LEN_W-1:0]  msg_len;
        logic [LEN_W-1:0]  frag_size;
        logic              last_flag;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  read_index;
    } t_frag_item;

    typedef struct packed {
        frasm_pkg::t_status status;
        logic [LEN_W-1:0]   msg_length;
        logic [FRAG_W-1:0]  frag_total;
        logic [BYTE_W-1:0]  read_byte;
    } t_frag_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op           = '0;
    logic [SEQ_W-1:0]    i_seq_id       = '0;
    logic [LEN_W-1:0]    i_msg_len      = '0;
    logic [LEN_W-1:0]    i_frag_size    = '0;
    logic                i_last_flag    = 1'b0;
    logic [BYTE_W-1:0]   i_payload_byte = '0;
    logic [IDX_W-1:0]    i_read_index   = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [LEN_W-1:0]    o_message_length;
    logic [FRAG_W-1:0]   o_fragment_total;
    logic [BYTE_W-1:0]   o_read_byte;

    fragment_reassembly dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_seq_id         (i_seq_id),
        .i_msg_len        (i_msg_len),
        .i_frag_size      (i_frag_size),
        .i_last_flag      (i_last_flag),
        .i_payload_byte   (i_payload_byte),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_message_length (o_message_length),
        .o_fragment_total (o_fragment_total),
        .o_read_byte      (o_read_byte)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_frag_item   item_queue[$];
    t_frag_result pending_results[$];

    int  reset_cycles   = 0;
    bit  in_beat_taken  = 1'b0;
    int  send_idle_pct  = 28;
    int  recv_idle_pct  = 76;
    int  total_items    = 0;
    int  directed_items = 0;
    int  noise_items    = 0;
    int  items_taken    = 0;
    int  results_seen   = 0;
    int  errors         = 0;
    int  idle_cycles    = 0;
    int  status_seen[8];
    int  gen_len        = 0;
    bit  gen_reads      = 1'b0;

    // Reassembly state mirror
    logic [BYTE_W-1:0] msg_store [MAX_BYTES];
    int                rx_count   = 0;
    int                exp_len    = 0;
    int                bytes_due  = 0;
    logic [SEQ_W-1:0]  last_seq   = '0;
    logic [FRAG_W-1:0] frags_done = '0;
    logic [SEQ_W-1:0]  cur_seq    = '0;
    bit                msg_open   = 1'b0;
    bit                cur_last   = 1'b0;

    function automatic frasm_pkg::t_status close_fragment();
        last_seq   = cur_seq;
        frags_done = frags_done + 16'd1;
        if (!cur_last)
            return frasm_pkg::ST_FRAG_DONE;
        if (rx_count != exp_len)
            return frasm_pkg::ST_INCOMPLETE;
        msg_open = 1'b0;
        return frasm_pkg::ST_COMPLETE;
    endfunction

    function automatic frasm_pkg::t_status header_status(t_frag_item it);
        bytes_due = 0;
        if (it.seq_id == 16'd1) begin
            // restart, even if the declared length turns out too big
            rx_count   = 0;
            last_seq   = '0;
            frags_done = '0;
            if (int'(it.msg_len) > MAX_BYTES) begin
                exp_len  = 0;
                msg_open = 1'b0;
                return frasm_pkg::ST_OVERFLOW;
            end
            exp_len  = int'(it.msg_len);
            msg_open = 1'b1;
        end
        if (!msg_open || it.seq_id != last_seq + 16'd1)
            return frasm_pkg::ST_SEQ_ERR;
        if (rx_count + int'(it.frag_size) > exp_len)
            return frasm_pkg::ST_OVERFLOW;
        cur_seq   = it.seq_id;
        cur_last  = it.last_flag;
        bytes_due = int'(it.frag_size);
        if (bytes_due == 0)
            return close_fragment();
        return frasm_pkg::ST_MORE;
    endfunction

    function automatic frasm_pkg::t_status payload_status(logic [BYTE_W-1:0] b);
        if (bytes_due == 0)
            return frasm_pkg::ST_UNEXPECTED;
        if (rx_count < MAX_BYTES)
            msg_store[rx_count] = b;
        rx_count++;
        bytes_due--;
        if (bytes_due == 0)
            return close_fragment();
        return frasm_pkg::ST_MORE;
    endfunction

    task automatic reassemble_item(input t_frag_item it);
        t_frag_result       r;
        frasm_pkg::t_status st;
        logic [BYTE_W-1:0]  rb;
        rb = '0;
        case (it.op)
            frasm_pkg::OP_HDR:     st = header_status(it);
            frasm_pkg::OP_PAYLOAD: st = payload_status(it.payload_byte);
            frasm_pkg::OP_READ: begin
                st = frasm_pkg::ST_READ;
                if (int'(it.read_index) < rx_count)
                    rb = msg_store[it.read_index];
            end
            default:               st = frasm_pkg::ST_UNEXPECTED;
        endcase
        r.status     = st;
        r.msg_length = LEN_W'(exp_len);
        r.frag_total = frags_done;
        r.read_byte  = rb;
        pending_results.push_back(r);
    endtask

    // ---------------- stimulus builders ----------------

    function automatic t_frag_item junk_item();
        t_frag_item it;
        it.op           = OP_UNUSED;
        it.seq_id       = SEQ_W'($urandom);
        it.msg_len      = LEN_W'($urandom);
        it.frag_size    = LEN_W'($urandom);
        it.last_flag    = 1'($urandom);
        it.payload_byte = BYTE_W'($urandom);
        it.read_index   = IDX_W'($urandom);
        return it;
    endfunction

    task automatic push_read(input logic [IDX_W-1:0] idx);
        t_frag_item it;
        it            = junk_item();
        it.op         = frasm_pkg::OP_READ;
        it.read_index = idx;
        item_queue.push_back(it);
    endtask

    task automatic maybe_read();
        int hi;
        hi = (gen_len + 2 > 4095) ? 4095 : gen_len + 2;
        if (gen_reads && $urandom_range(99) < 6) begin
            if ($urandom_range(9) < 7)
                push_read(IDX_W'($urandom_range(0, hi)));
            else
                push_read(IDX_W'($urandom_range(0, 4095)));
        end
    endtask

    task automatic push_header(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] mlen,
                               input logic [LEN_W-1:0] flen, input logic fin);
        t_frag_item it;
        it           = junk_item();
        it.op        = frasm_pkg::OP_HDR;
        it.seq_id    = seq;
        it.msg_len   = mlen;
        it.frag_size = flen;
        it.last_flag = fin;
        item_queue.push_back(it);
        maybe_read();
    endtask

    task automatic push_payload(input logic [BYTE_W-1:0] b);
        t_frag_item it;
        it              = junk_item();
        it.op           = frasm_pkg::OP_PAYLOAD;
        it.payload_byte = b;
        item_queue.push_back(it);
        maybe_read();
    endtask

    task automatic push_bytes(input int n);
        for (int i = 0; i < n; i++)
            push_payload(BYTE_W'($urandom));
    endtask

    task automatic push_noise(input bit stray);
        t_frag_item it;
        it = junk_item();
        if (stray)
            it.op = frasm_pkg::OP_PAYLOAD;
        item_queue.push_back(it);
        noise_items++;
    endtask

    // One message: mostly clean fragment sequences, with the odd fault mixed in
    task automatic gen_message();
        int               mlen, left, flen, pushed, pick, guard, nreads;
        logic [SEQ_W-1:0] seq, bad;
        bit               stop;
        pick = $urandom_range(99);
        if (pick < 4) begin
            push_header(16'd1, LEN_W'($urandom_range(4097, 8191)),
                        LEN_W'($urandom_range(0, 8191)), 1'($urandom));
            return;
        end
        if (pick < 8) begin
            push_header(SEQ_W'($urandom), LEN_W'($urandom), LEN_W'($urandom), 1'($urandom));
            return;
        end
        if (pick < 11)
            mlen = 0;
        else if (pick < 90)
            mlen = $urandom_range(1, 40);
        else
            mlen = $urandom_range(41, 300);
        gen_len = mlen;
        left    = mlen;
        seq     = 16'd1;
        stop    = 1'b0;
        guard   = 0;
        do begin
            if (left == 0 || $urandom_range(19) == 0)
                flen = 0;
            else
                flen = $urandom_range(1, (left < 16) ? left : 16);
            pick = $urandom_range(99);
            if (pick < 4 && seq != 16'd1) begin
                bad = seq + SEQ_W'($urandom_range(2, 65534));
                if (bad == 16'd1)
                    bad = 16'd0;
                push_header(bad, LEN_W'($urandom), LEN_W'(flen), 1'(flen == left));
            end else if (pick < 7) begin
                push_header(seq, LEN_W'(mlen), LEN_W'(left + $urandom_range(1, 8)), 1'b0);
            end else if (pick < 11 && flen >= 2) begin
                // header arrives before the fragment is finished
                push_header(seq, LEN_W'(mlen), LEN_W'(flen), 1'(flen == left));
                pushed = $urandom_range(1, flen - 1);
                push_bytes(pushed);
                if (seq != 16'd1)
                    left -= pushed;
            end else if (pick < 14 && flen < left) begin
                // last flag too early: incomplete, message stays open
                push_header(seq, LEN_W'(mlen), LEN_W'(flen), 1'b1);
                push_bytes(flen);
                seq++;
                left -= flen;
            end else if (pick < 16) begin
                stop = 1'b1;
            end else begin
                push_header(seq, LEN_W'(mlen), LEN_W'(flen), 1'(flen == left));
                push_bytes(flen);
                seq++;
                left -= flen;
                if ($urandom_range(29) == 0)
                    push_noise(1'b1);
            end
            if ($urandom_range(49) == 0)
                push_noise(1'b0);
            guard++;
        end while ((left > 0 || seq == 16'd1) && !stop && guard < 200);
        nreads = $urandom_range(0, 3);
        for (int i = 0; i < nreads; i++)
            push_read(IDX_W'($urandom_range(0, mlen + 1)));
        if ($urandom_range(19) == 0)
            push_header(seq, LEN_W'($urandom), LEN_W'($urandom_range(0, 4)), 1'b1);
    endtask

    // ---------------- driver ----------------

    always @(negedge i_clk) begin : driver
        t_frag_item it;
        if (reset_cycles < RESET_CYCLES) begin
            reset_cycles <= reset_cycles + 1;
            if (reset_cycles == RESET_CYCLES - 1)
                i_rst_n <= 1'b1;
        end else begin
            // a stalled beat is held as it is
            if (!(i_in_valid && !in_beat_taken)) begin
                if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it             = item_queue[0];
                    i_in_valid     <= 1'b1;
                    i_op           <= it.op;
                    i_seq_id       <= it.seq_id;
                    i_msg_len      <= it.msg_len;
                    i_frag_size    <= it.frag_size;
                    i_last_flag    <= it.last_flag;
                    i_payload_byte <= it.payload_byte;
                    i_read_index   <= it.read_index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ---------------- monitor, prediction, watchdog ----------------

    // reports list status/length/fragments/byte
    always @(posedge i_clk) begin : monitor
        t_frag_result want;
        t_frag_item   it;
        bit           beat;
        beat = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beat = 1'b1;
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: expected nothing, got %0d/%0d/%0d/%0h",
                             $time, o_status, o_message_length, o_fragment_total,
                             o_read_byte);
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (o_status !== want.status || o_message_length !== want.msg_length ||
                    o_fragment_total !== want.frag_total || o_read_byte !== want.read_byte) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: expected %0d/%0d/%0d/%0h, got %0d/%0d/%0d/%0h",
                                 $time, want.status, want.msg_length, want.frag_total,
                                 want.read_byte, o_status, o_message_length,
                                 o_fragment_total, o_read_byte);
                end
            end
        end
        in_beat_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_beat_taken) begin
            beat = 1'b1;
            it   = item_queue.pop_front();
            reassemble_item(it);
            items_taken++;
        end
        if (items_taken < total_items / 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 76;
        end else if (items_taken < 2 * total_items / 3) begin
            send_idle_pct = 76;
            recv_idle_pct = 28;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (i_rst_n) begin
            idle_cycles = beat ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d items left, %0d results pending",
                         $time, idle_cycles, item_queue.size(), pending_results.size());
                $display("fragment_reassembly: mismatch");
                $finish;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        foreach (status_seen[i])
            status_seen[i] = 0;

        // directed: errors from reset, oversize lengths, then messages and faults
        push_read(12'd0);
        push_noise(1'b1);
        push_noise(1'b0);
        push_header(16'd2, 13'd10, 13'd1, 1'b0);
        push_header(16'd1, 13'h1FFF, 13'd0, 1'b0);
        push_header(16'd1, 13'd4097, 13'd5, 1'b1);
        push_header(16'd1, 13'd4096, 13'h1FFF, 1'b1);
        push_header(16'd1, 13'd4, 13'd0, 1'b0);
        push_header(16'd2, 13'd0, 13'd2, 1'b0);
        push_payload(8'h00);
        push_header(16'd2, 13'd0, 13'd1, 1'b1);
        push_payload(8'hFF);
        push_header(16'd3, 13'd0, 13'd2, 1'b1);
        push_payload(8'hA5);
        push_payload(8'h5A);
        push_read(12'd0);
        push_read(12'd3);
        push_read(12'd4);
        push_read(12'hFFF);
        push_header(16'd4, 13'd0, 13'd1, 1'b0);
        push_header(16'd1, 13'd0, 13'd0, 1'b1);
        push_header(16'hFFFF, 13'h1FFF, 13'h1FFF, 1'b1);
        push_header(16'd1, 13'd4096, 13'd3, 1'b0);
        push_payload(8'h3C);
        push_header(16'd3, 13'd0, 13'd1, 1'b0);
        directed_items = item_queue.size();

        gen_reads = 1'b1;
        while (item_queue.size() - noise_items < TARGET_ITEMS + directed_items)
            gen_message();
        total_items = item_queue.size();

        while (item_queue.size() != 0 || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d item beats (%0d directed), checked %0d results, %0d reads, %0d stray",
                 items_taken, directed_items, results_seen,
                 status_seen[frasm_pkg::ST_READ], status_seen[frasm_pkg::ST_UNEXPECTED]);
        $display("complete %0d, incomplete %0d, fragment done %0d, seq error %0d, overflow %0d",
                 status_seen[frasm_pkg::ST_COMPLETE], status_seen[frasm_pkg::ST_INCOMPLETE],
                 status_seen[frasm_pkg::ST_FRAG_DONE], status_seen[frasm_pkg::ST_SEQ_ERR],
                 status_seen[frasm_pkg::ST_OVERFLOW]);
        if (errors == 0)
            $display("fragment_reassembly: match");
        else
            $display("fragment_reassembly: mismatch");
        $finish;
    end

endmodule

// ===== fragment_reassembly.f =====
rtl/core/frasm_pkg.sv
rtl/core/frasm_ram.sv
rtl/core/fragment_reassembly.sv
tb/sv/fragment_reassembly_test.sv
